// File: hdl/lcsp_pkg.sv
// ----------------------------------------------------------------------------
// lcsp_pkg
// Types and constants shared by the command sequence player modules.
// ----------------------------------------------------------------------------
package lcsp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned TicksW = 16;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  localparam logic [0:0] RegTicksPerUnit = 1'b0;
  localparam logic [TicksW-1:0] TicksReset = 16'd1;

  localparam logic OpByte = 1'b0;
  localparam logic OpTick = 1'b1;

  typedef enum logic [2:0] {
    PH_FIRST_CMD = 3'd0,
    PH_ARGC      = 3'd1,
    PH_ARGS      = 3'd2,
    PH_DELAY     = 3'd3,
    PH_WAIT      = 3'd4,
    PH_NEXT      = 3'd5
  } lcsp_phase_t;

  typedef struct packed {
    logic             operation;
    logic [ByteW-1:0] table_byte;
  } lcsp_item_t;

  typedef struct packed {
    logic             serial_valid;
    logic [ByteW-1:0] serial_byte;
    logic             dc_line;
    logic             cs_line;
    logic             waiting;
    logic             sequence_done;
    logic             byte_dropped;
  } lcsp_result_t;

  typedef struct packed {
    logic item_valid;
    logic advance;
  } lcsp_ctrl_t;

endpackage

// File: hdl/lcsp_in_reg.sv
// ----------------------------------------------------------------------------
// lcsp_in_reg
// Input register stage; holds one word until the core can take it.
// ----------------------------------------------------------------------------
module lcsp_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lcsp_pkg::lcsp_item_t in_item,
  input  logic                advance,
  output lcsp_pkg::lcsp_ctrl_t ctrl,
  output lcsp_pkg::lcsp_item_t item
);
  import lcsp_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  lcsp_item_t item_r;
  logic       load;

  assign in_stall = valid_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign ctrl.item_valid = valid_r;
  assign ctrl.advance    = advance;
  assign item            = item_r;

endmodule

// File: hdl/lcsp_core.sv
// ----------------------------------------------------------------------------
// lcsp_core
// Sequence state machine, delay prescaler and the result register.
// ----------------------------------------------------------------------------
module lcsp_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lcsp_pkg::lcsp_ctrl_t        ctrl,
  input  lcsp_pkg::lcsp_item_t        item,
  input  logic [lcsp_pkg::TicksW-1:0] ticks_per_unit,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic                        advance,
  output lcsp_pkg::lcsp_result_t      result
);
  import lcsp_pkg::*;

  lcsp_phase_t       phase_r, phase_nxt;
  logic [ByteW-1:0]  args_left_r, args_left_nxt;
  logic [ByteW-1:0]  delay_left_r, delay_left_nxt;
  logic [TicksW-1:0] prescale_r, prescale_nxt;
  logic              cs_r, cs_nxt;
  logic              dc_r, dc_nxt;
  logic              out_valid_r, out_valid_nxt;
  lcsp_result_t      result_r, result_nxt;

  logic [TicksW-1:0] limit;
  logic [TicksW-1:0] prescale_inc;
  logic [ByteW-1:0]  args_dec;
  logic [ByteW-1:0]  delay_dec;
  logic              take;

  assign advance = !out_valid_r || !out_stall;
  assign take    = ctrl.item_valid && ctrl.advance;

  assign limit        = (ticks_per_unit == '0) ? TicksW'(1) : ticks_per_unit;
  assign prescale_inc = prescale_r + TicksW'(1);
  assign args_dec     = args_left_r - ByteW'(1);
  assign delay_dec    = delay_left_r - ByteW'(1);

  always_comb begin
    phase_nxt      = phase_r;
    args_left_nxt  = args_left_r;
    delay_left_nxt = delay_left_r;
    prescale_nxt   = prescale_r;
    cs_nxt         = cs_r;
    dc_nxt         = dc_r;
    result_nxt     = '0;

    if (item.operation == OpTick) begin
      if (phase_r == PH_WAIT) begin
        prescale_nxt = prescale_inc;
        if (prescale_inc >= limit) begin
          prescale_nxt   = '0;
          delay_left_nxt = delay_dec;
          if (delay_dec == '0) begin
            cs_nxt    = 1'b1;
            phase_nxt = PH_NEXT;
          end
        end
      end
    end else begin
      unique case (phase_r) inside
        PH_NEXT, PH_FIRST_CMD: begin
          if (phase_r == PH_NEXT && item.table_byte == '0) begin
            result_nxt.sequence_done = 1'b1;
            phase_nxt                = PH_FIRST_CMD;
          end else begin
            dc_nxt                  = 1'b0;
            cs_nxt                  = 1'b0;
            result_nxt.serial_valid = 1'b1;
            result_nxt.serial_byte  = item.table_byte;
            phase_nxt               = PH_ARGC;
          end
        end
        PH_ARGC: begin
          args_left_nxt = item.table_byte;
          if (item.table_byte != '0) begin
            dc_nxt    = 1'b1;
            phase_nxt = PH_ARGS;
          end else begin
            phase_nxt = PH_DELAY;
          end
        end
        PH_ARGS: begin
          result_nxt.serial_valid = 1'b1;
          result_nxt.serial_byte  = item.table_byte;
          args_left_nxt           = args_dec;
          if (args_dec == '0) begin
            phase_nxt = PH_DELAY;
          end
        end
        PH_DELAY: begin
          if (item.table_byte != '0) begin
            delay_left_nxt = item.table_byte;
            prescale_nxt   = '0;
            phase_nxt      = PH_WAIT;
          end else begin
            cs_nxt    = 1'b1;
            phase_nxt = PH_NEXT;
          end
        end
        PH_WAIT: begin
          result_nxt.byte_dropped = 1'b1;
        end
        default: begin
          phase_nxt = PH_FIRST_CMD;
        end
      endcase
    end

    result_nxt.dc_line = dc_nxt;
    result_nxt.cs_line = cs_nxt;
    result_nxt.waiting = (phase_nxt == PH_WAIT);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (advance) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_FIRST_CMD;
      args_left_r  <= '0;
      delay_left_r <= '0;
      prescale_r   <= '0;
      cs_r         <= 1'b1;
      dc_r         <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        phase_r      <= phase_nxt;
        args_left_r  <= args_left_nxt;
        delay_left_r <= delay_left_nxt;
        prescale_r   <= prescale_nxt;
        cs_r         <= cs_nxt;
        dc_r         <= dc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

// File: hdl/lcd_command_sequence_player_top.sv
// ----------------------------------------------------------------------------
// lcd_command_sequence_player_top
// Plays a display command table one byte per word and drives the serial
// byte, data/command and chip select levels, with table delays timed by ticks.
// ----------------------------------------------------------------------------
// Every input word, table byte or tick, gives exactly one result word. A word
// passes through an input register and the state machine into the result
// register, where its result word is held, and a new word is accepted every
// cycle while the result side is not stalled. The delay prescaler limit is
// set through the register at byte address 0 (zero acts as one) and should be
// written only while no words are in flight.
module lcd_command_sequence_player_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_operation,
  input  logic [7:0]                  in_table_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_serial_valid,
  output logic [7:0]                  out_serial_byte,
  output logic                        out_dc_line,
  output logic                        out_cs_line,
  output logic                        out_waiting,
  output logic                        out_sequence_done,
  output logic                        out_byte_dropped,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcsp_pkg::AddrW-1:0]  paddr,
  input  logic [lcsp_pkg::DataW-1:0]  pwdata,
  output logic [lcsp_pkg::DataW-1:0]  prdata,
  output logic                        pready
);
  import lcsp_pkg::*;

  logic [TicksW-1:0] ticks_r;
  logic              reg_hit;
  logic              advance;
  lcsp_item_t        in_item;
  lcsp_item_t        item;
  lcsp_ctrl_t        ctrl;
  lcsp_result_t      result;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[AddrW-1:2] == RegTicksPerUnit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= TicksReset;
    end else if (psel && penable && pwrite && reg_hit) begin
      ticks_r <= pwdata[TicksW-1:0];
    end
  end

  assign prdata = reg_hit ? {{(DataW-TicksW){1'b0}}, ticks_r} : '0;

  assign in_item.operation  = in_operation;
  assign in_item.table_byte = in_table_byte;

  lcsp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .ctrl     (ctrl),
    .item     (item)
  );

  lcsp_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .item           (item),
    .ticks_per_unit (ticks_r),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .advance        (advance),
    .result         (result)
  );

  assign out_serial_valid  = result.serial_valid;
  assign out_serial_byte   = result.serial_byte;
  assign out_dc_line       = result.dc_line;
  assign out_cs_line       = result.cs_line;
  assign out_waiting       = result.waiting;
  assign out_sequence_done = result.sequence_done;
  assign out_byte_dropped  = result.byte_dropped;

endmodule
